// ----- sv/gtg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants of the go-to-goal velocity block
// Formats, widths, the CORDIC angle table and the stage payload records.
// ----------------------------------------------------------------------------
package gtg_pkg;

  // Field widths
  localparam int unsigned POS_W  = 16;   // signed Q5.10 positions
  localparam int unsigned HEAD_W = 15;   // signed Q2.12 radians
  localparam int unsigned GAIN_W = 8;    // unsigned Q4.4 gains
  localparam int unsigned LIN_W  = 20;   // unsigned Q10.10 speed
  localparam int unsigned ANG_W  = 20;   // signed Q7.12 turn rate

  // Datapath widths
  localparam int unsigned DIFF_W      = POS_W + 1;            // goal minus pose
  localparam int unsigned SQ1_W       = 2 * POS_W;            // one square
  localparam int unsigned SQ_W        = SQ1_W + 1;            // sum of squares
  localparam int unsigned RAD_SHIFT   = 8;                    // radicand scale
  localparam int unsigned RAD_W       = ((SQ_W + RAD_SHIFT + 1) / 2) * 2;
  localparam int unsigned SQRT_BITS   = RAD_W / 2;            // root bits
  localparam int unsigned REM_W       = SQRT_BITS + 3;        // partial remainder
  localparam int unsigned CORDIC_SH   = 8;                    // vector scale
  localparam int unsigned CORDIC_W    = 28;                   // x/y datapath
  localparam int unsigned Z_W         = 20;                   // angle, Q16 rad
  localparam int unsigned ZD_W        = Z_W + 1;              // bearing - heading
  localparam int unsigned HEAD_SH     = 4;                    // Q12 -> Q16
  localparam int unsigned FRAC_SHIFT  = 8;                    // gain product scale
  localparam int unsigned ROUND       = 1 << (FRAC_SHIFT - 1);
  localparam int unsigned LIN_PROD_W  = GAIN_W + SQRT_BITS;
  localparam int unsigned ANG_PROD_W  = GAIN_W + 1 + ZD_W;

  // CORDIC
  localparam int unsigned ATAN_LEN         = 24;
  localparam int unsigned STEP_IDX_W       = $clog2(ATAN_LEN);
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam logic signed [Z_W-1:0] PI_Q16 = 20'sd205887;

  // Saturation limits
  localparam logic [LIN_W-1:0]        LIN_MAX = '1;
  localparam logic signed [ANG_W-1:0] ANG_MAX = 20'sh7FFFF;
  localparam logic signed [ANG_W-1:0] ANG_MIN = 20'sh80000;

  // Configuration registers
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = GAIN_W;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_LINEAR_GAIN  = 1'd0;
  localparam cfg_idx_t CFG_ANGULAR_GAIN = 1'd1;
  localparam logic [GAIN_W-1:0] LIN_GAIN_RST = 8'd24;   // 1.5
  localparam logic [GAIN_W-1:0] ANG_GAIN_RST = 8'd128;  // 8.0

  // round(atan(2^-i) * 2^16)
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [STEP_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] val;
    case (idx)
      5'd0:    val = 20'sd51472;
      5'd1:    val = 20'sd30386;
      5'd2:    val = 20'sd16055;
      5'd3:    val = 20'sd8150;
      5'd4:    val = 20'sd4091;
      5'd5:    val = 20'sd2047;
      5'd6:    val = 20'sd1024;
      5'd7:    val = 20'sd512;
      5'd8:    val = 20'sd256;
      5'd9:    val = 20'sd128;
      5'd10:   val = 20'sd64;
      5'd11:   val = 20'sd32;
      5'd12:   val = 20'sd16;
      5'd13:   val = 20'sd8;
      5'd14:   val = 20'sd4;
      5'd15:   val = 20'sd2;
      5'd16:   val = 20'sd1;
      default: val = '0;
    endcase
    return val;
  endfunction

  // Front end to iterative core
  typedef struct packed {
    logic [RAD_W-1:0]           rad;
    logic signed [CORDIC_W-1:0] cx;
    logic signed [CORDIC_W-1:0] cy;
    logic signed [Z_W-1:0]      cz;
    logic                       zero;
    logic signed [HEAD_W-1:0]   head;
  } front_t;

  // Iterative core to gain stages
  typedef struct packed {
    logic [SQRT_BITS-1:0]     distance;
    logic signed [Z_W-1:0]    bearing;
    logic signed [HEAD_W-1:0] head;
  } core_t;

endpackage

// ----- sv/gtg_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_in_if: pose and goal channel
// Valid/ready channel carrying one robot pose and one goal point per beat.
// ----------------------------------------------------------------------------
interface gtg_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [gtg_pkg::POS_W-1:0]   robot_x;
  logic signed [gtg_pkg::POS_W-1:0]   robot_y;
  logic signed [gtg_pkg::HEAD_W-1:0]  robot_heading;
  logic signed [gtg_pkg::POS_W-1:0]   goal_x;
  logic signed [gtg_pkg::POS_W-1:0]   goal_y;

  modport source (output valid, robot_x, robot_y, robot_heading, goal_x, goal_y,
                  input ready);
  modport sink (input valid, robot_x, robot_y, robot_heading, goal_x, goal_y,
                output ready);
endinterface

// ----- sv/gtg_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_out_if: velocity command channel
// Valid/ready channel carrying one linear and one angular speed per beat.
// ----------------------------------------------------------------------------
interface gtg_out_if;
  logic                              valid;
  logic                              ready;
  logic [gtg_pkg::LIN_W-1:0]         linear_speed;
  logic signed [gtg_pkg::ANG_W-1:0]  angular_speed;

  modport source (output valid, linear_speed, angular_speed, input ready);
  modport sink (input valid, linear_speed, angular_speed, output ready);
endinterface

// ----- sv/gtg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_front: difference, squares and CORDIC setup
// Three stages: goal minus pose, squares and half-plane fold, radicand sum.
// ----------------------------------------------------------------------------
module gtg_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [gtg_pkg::POS_W-1:0]  robot_x_i,
  input  logic signed [gtg_pkg::POS_W-1:0]  robot_y_i,
  input  logic signed [gtg_pkg::HEAD_W-1:0] robot_heading_i,
  input  logic signed [gtg_pkg::POS_W-1:0]  goal_x_i,
  input  logic signed [gtg_pkg::POS_W-1:0]  goal_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output gtg_pkg::front_t                   out_o
);

  localparam int unsigned NST = 3;

  logic [NST-1:0] v_q;
  logic [NST-1:0] rdy;

  // stage 0
  logic signed [gtg_pkg::DIFF_W-1:0] dx_q, dy_q;
  logic signed [gtg_pkg::HEAD_W-1:0] hd0_q;
  // stage 1
  logic [gtg_pkg::SQ1_W-1:0]                sqx_q, sqy_q;
  logic signed [gtg_pkg::CORDIC_W-1:0]      cx1_q, cy1_q;
  logic signed [gtg_pkg::Z_W-1:0]           cz1_q;
  logic                                     zero1_q;
  logic signed [gtg_pkg::HEAD_W-1:0]        hd1_q;
  // stage 2
  gtg_pkg::front_t                          pl2_q;

  logic signed [2*gtg_pkg::DIFF_W-1:0] sqx_full, sqy_full;
  logic                                neg;
  logic signed [gtg_pkg::DIFF_W-1:0]   ax, ay;
  logic signed [gtg_pkg::Z_W-1:0]      cz_d;
  logic [gtg_pkg::SQ_W-1:0]            sum_d;

  // a stage takes a new beat when it is empty or its successor moves on
  assign rdy[2]      = !v_q[2] || out_ready_i;
  assign rdy[1]      = !v_q[1] || rdy[2];
  assign rdy[0]      = !v_q[0] || rdy[1];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[2];
  assign out_o       = pl2_q;

  assign sqx_full = dx_q * dx_q;
  assign sqy_full = dy_q * dy_q;

  // fold the left half-plane onto the right one
  always_comb begin
    neg  = dx_q[gtg_pkg::DIFF_W-1];
    ax   = neg ? -dx_q : dx_q;
    ay   = neg ? -dy_q : dy_q;
    cz_d = '0;
    if (neg) begin
      cz_d = dy_q[gtg_pkg::DIFF_W-1] ? -gtg_pkg::PI_Q16 : gtg_pkg::PI_Q16;
    end
  end

  assign sum_d = gtg_pkg::SQ_W'(sqx_q) + gtg_pkg::SQ_W'(sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      dx_q  <= gtg_pkg::DIFF_W'(goal_x_i) - gtg_pkg::DIFF_W'(robot_x_i);
      dy_q  <= gtg_pkg::DIFF_W'(goal_y_i) - gtg_pkg::DIFF_W'(robot_y_i);
      hd0_q <= robot_heading_i;
    end
    if (rdy[1] && v_q[0]) begin
      sqx_q   <= sqx_full[gtg_pkg::SQ1_W-1:0];
      sqy_q   <= sqy_full[gtg_pkg::SQ1_W-1:0];
      cx1_q   <= gtg_pkg::CORDIC_W'(ax) <<< gtg_pkg::CORDIC_SH;
      cy1_q   <= gtg_pkg::CORDIC_W'(ay) <<< gtg_pkg::CORDIC_SH;
      cz1_q   <= cz_d;
      zero1_q <= (dx_q == '0) && (dy_q == '0);
      hd1_q   <= hd0_q;
    end
    if (rdy[2] && v_q[1]) begin
      pl2_q.rad  <= gtg_pkg::RAD_W'({sum_d, gtg_pkg::RAD_SHIFT'(0)});
      pl2_q.cx   <= cx1_q;
      pl2_q.cy   <= cy1_q;
      pl2_q.cz   <= cz1_q;
      pl2_q.zero <= zero1_q;
      pl2_q.head <= hd1_q;
    end
  end

endmodule

// ----- sv/gtg_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_core: pipelined square root and CORDIC vectoring
// One root bit and one micro-rotation per stage, side by side.
// ----------------------------------------------------------------------------
module gtg_core #(
  parameter int unsigned CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned STAGES       = gtg_pkg::SQRT_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gtg_pkg::front_t in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output gtg_pkg::core_t  out_o
);

  logic [STAGES-1:0] v_q;
  logic [STAGES-1:0] rdy;

  logic [gtg_pkg::RAD_W-1:0]           rad_s  [STAGES];
  logic [gtg_pkg::REM_W-1:0]           rem_s  [STAGES];
  logic [gtg_pkg::SQRT_BITS-1:0]       root_s [STAGES];
  logic signed [gtg_pkg::CORDIC_W-1:0] cx_s   [STAGES];
  logic signed [gtg_pkg::CORDIC_W-1:0] cy_s   [STAGES];
  logic signed [gtg_pkg::Z_W-1:0]      cz_s   [STAGES];
  logic                                zero_s [STAGES];
  logic signed [gtg_pkg::HEAD_W-1:0]   hd_s   [STAGES];
  logic                                vin_s  [STAGES];

  logic [gtg_pkg::RAD_W-1:0]           rad_q  [STAGES];
  logic [gtg_pkg::REM_W-1:0]           rem_q  [STAGES];
  logic [gtg_pkg::SQRT_BITS-1:0]       root_q [STAGES];
  logic signed [gtg_pkg::CORDIC_W-1:0] cx_q   [STAGES];
  logic signed [gtg_pkg::CORDIC_W-1:0] cy_q   [STAGES];
  logic signed [gtg_pkg::Z_W-1:0]      cz_q   [STAGES];
  logic                                zero_q [STAGES];
  logic signed [gtg_pkg::HEAD_W-1:0]   hd_q   [STAGES];

  // back-pressure runs from the last stage towards the first
  always_comb begin
    rdy[STAGES-1] = !v_q[STAGES-1] || out_ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[STAGES-1];
  assign out_o.distance = root_q[STAGES-1];
  assign out_o.bearing  = zero_q[STAGES-1] ? '0 : cz_q[STAGES-1];
  assign out_o.head     = hd_q[STAGES-1];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam bit DO_SQRT   = (k < gtg_pkg::SQRT_BITS);
    localparam bit DO_CORDIC = (k < CORDIC_STEPS);

    logic [gtg_pkg::REM_W-1:0]           rem_sh, trial;
    logic signed [gtg_pkg::CORDIC_W-1:0] xs, ys;
    logic signed [gtg_pkg::Z_W-1:0]      ang;
    logic [gtg_pkg::RAD_W-1:0]           rad_d;
    logic [gtg_pkg::REM_W-1:0]           rem_d;
    logic [gtg_pkg::SQRT_BITS-1:0]       root_d;
    logic signed [gtg_pkg::CORDIC_W-1:0] cx_d, cy_d;
    logic signed [gtg_pkg::Z_W-1:0]      cz_d;

    if (k == 0) begin : g_head
      assign vin_s[k]  = in_valid_i;
      assign rad_s[k]  = in_i.rad;
      assign rem_s[k]  = '0;
      assign root_s[k] = '0;
      assign cx_s[k]   = in_i.cx;
      assign cy_s[k]   = in_i.cy;
      assign cz_s[k]   = in_i.cz;
      assign zero_s[k] = in_i.zero;
      assign hd_s[k]   = in_i.head;
    end else begin : g_link
      assign vin_s[k]  = v_q[k-1];
      assign rad_s[k]  = rad_q[k-1];
      assign rem_s[k]  = rem_q[k-1];
      assign root_s[k] = root_q[k-1];
      assign cx_s[k]   = cx_q[k-1];
      assign cy_s[k]   = cy_q[k-1];
      assign cz_s[k]   = cz_q[k-1];
      assign zero_s[k] = zero_q[k-1];
      assign hd_s[k]   = hd_q[k-1];
    end

    always_comb begin
      // restoring square root: bring down two radicand bits, try root*4+1
      rem_sh = {rem_s[k][gtg_pkg::REM_W-3:0], rad_s[k][gtg_pkg::RAD_W-1 -: 2]};
      trial  = gtg_pkg::REM_W'({root_s[k], 2'b01});
      rad_d  = rad_s[k];
      rem_d  = rem_s[k];
      root_d = root_s[k];
      if (DO_SQRT) begin
        rad_d = rad_s[k] << 2;
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_s[k][gtg_pkg::SQRT_BITS-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_s[k][gtg_pkg::SQRT_BITS-2:0], 1'b0};
        end
      end
      // vectoring micro-rotation drives y towards zero
      xs   = cx_s[k] >>> k;
      ys   = cy_s[k] >>> k;
      ang  = gtg_pkg::atan_q16(gtg_pkg::STEP_IDX_W'(k));
      cx_d = cx_s[k];
      cy_d = cy_s[k];
      cz_d = cz_s[k];
      if (DO_CORDIC) begin
        if (!cy_s[k][gtg_pkg::CORDIC_W-1]) begin
          cx_d = cx_s[k] + ys;
          cy_d = cy_s[k] - xs;
          cz_d = cz_s[k] + ang;
        end else begin
          cx_d = cx_s[k] - ys;
          cy_d = cy_s[k] + xs;
          cz_d = cz_s[k] - ang;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= vin_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vin_s[k]) begin
        rad_q[k]  <= rad_d;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        cx_q[k]   <= cx_d;
        cy_q[k]   <= cy_d;
        cz_q[k]   <= cz_d;
        zero_q[k] <= zero_s[k];
        hd_q[k]   <= hd_s[k];
      end
    end
  end

endmodule

// ----- sv/gtg_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_back: gain multiply, rounding and saturation
// Three stages: heading error, gain products, rounded and clipped outputs.
// ----------------------------------------------------------------------------
module gtg_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [gtg_pkg::GAIN_W-1:0]        linear_gain_i,
  input  logic [gtg_pkg::GAIN_W-1:0]        angular_gain_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  gtg_pkg::core_t                    in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gtg_pkg::LIN_W-1:0]         linear_speed_o,
  output logic signed [gtg_pkg::ANG_W-1:0]  angular_speed_o
);

  localparam int unsigned NST       = 3;
  localparam int unsigned LIN_SUM_W = gtg_pkg::LIN_PROD_W + 1;
  localparam int unsigned ANG_SUM_W = gtg_pkg::ANG_PROD_W + 1;
  localparam logic signed [ANG_SUM_W-1:0] ANG_HI = ANG_SUM_W'(gtg_pkg::ANG_MAX);
  localparam logic signed [ANG_SUM_W-1:0] ANG_LO = ANG_SUM_W'(gtg_pkg::ANG_MIN);

  logic [NST-1:0] v_q;
  logic [NST-1:0] rdy;

  logic signed [gtg_pkg::ZD_W-1:0]       diff_q;
  logic [gtg_pkg::SQRT_BITS-1:0]         dist_q;
  logic [gtg_pkg::LIN_PROD_W-1:0]        lin_prod_q;
  logic signed [gtg_pkg::ANG_PROD_W-1:0] ang_prod_q;
  logic [gtg_pkg::LIN_W-1:0]             lin_q;
  logic signed [gtg_pkg::ANG_W-1:0]      ang_q;

  logic signed [gtg_pkg::ZD_W-1:0]       diff_d;
  logic signed [gtg_pkg::GAIN_W:0]       ang_gain_s;
  logic signed [gtg_pkg::ANG_PROD_W-1:0] ang_prod_d;
  logic [gtg_pkg::LIN_PROD_W-1:0]        lin_prod_d;
  logic [LIN_SUM_W-1:0]                  lin_sum, lin_sh;
  logic signed [ANG_SUM_W-1:0]           ang_sum, ang_sh;
  logic [gtg_pkg::LIN_W-1:0]             lin_d;
  logic signed [gtg_pkg::ANG_W-1:0]      ang_d;

  assign rdy[2]      = !v_q[2] || out_ready_i;
  assign rdy[1]      = !v_q[1] || rdy[2];
  assign rdy[0]      = !v_q[0] || rdy[1];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[2];
  assign linear_speed_o  = lin_q;
  assign angular_speed_o = ang_q;

  // heading moves from Q12 to Q16 before the subtract; no angle wrap
  assign diff_d = gtg_pkg::ZD_W'(in_i.bearing)
                - (gtg_pkg::ZD_W'(in_i.head) <<< gtg_pkg::HEAD_SH);

  assign ang_gain_s = signed'({1'b0, angular_gain_i});
  assign ang_prod_d = ang_gain_s * diff_q;
  assign lin_prod_d = gtg_pkg::LIN_PROD_W'(linear_gain_i)
                    * gtg_pkg::LIN_PROD_W'(dist_q);

  // round half up, then clip
  always_comb begin
    lin_sum = LIN_SUM_W'(lin_prod_q) + LIN_SUM_W'(gtg_pkg::ROUND);
    lin_sh  = lin_sum >> gtg_pkg::FRAC_SHIFT;
    lin_d   = (lin_sh > LIN_SUM_W'(gtg_pkg::LIN_MAX)) ? gtg_pkg::LIN_MAX
                                                      : lin_sh[gtg_pkg::LIN_W-1:0];
    ang_sum = ANG_SUM_W'(ang_prod_q) + signed'(ANG_SUM_W'(gtg_pkg::ROUND));
    ang_sh  = ang_sum >>> gtg_pkg::FRAC_SHIFT;
    if (ang_sh > ANG_HI) begin
      ang_d = gtg_pkg::ANG_MAX;
    end else if (ang_sh < ANG_LO) begin
      ang_d = gtg_pkg::ANG_MIN;
    end else begin
      ang_d = ang_sh[gtg_pkg::ANG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      diff_q <= diff_d;
      dist_q <= in_i.distance;
    end
    if (rdy[1] && v_q[0]) begin
      lin_prod_q <= lin_prod_d;
      ang_prod_q <= ang_prod_d;
    end
    if (rdy[2] && v_q[1]) begin
      lin_q <= lin_d;
      ang_q <= ang_d;
    end
  end

endmodule

// ----- sv/go_to_goal_velocity.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_velocity: proportional go-to-goal controller
// Distance and bearing from pose to goal, scaled by two gains into a
// saturated linear speed and turn rate.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Beat contents                                   Format
//  in_ch     in   robot_x, robot_y, robot_heading, goal_x, goal_y  Q5.10 / Q2.12
//  out_ch    out  linear_speed, angular_speed                      Q10.10 / Q7.12
//  cfg_*     in   gain write: index 0 linear, 1 angular             unsigned Q4.4
//
//  One beat enters per cycle and one result leaves per cycle while out_ch is ready.
//  The pipeline holds three front stages, one core stage per root bit /
//  micro-rotation, and three gain stages.
//  Reset clears every valid bit and loads the gains to 1.5 and 8.0.
//  Back-pressure propagates stage by stage: empty stages keep filling while
//  the output register holds a result, so nothing is dropped or duplicated.
//  Gains are read live by the multiply stage; write them only while idle.
//
module go_to_goal_velocity #(
  parameter int unsigned CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  gtg_in_if.sink                             in_ch,
  gtg_out_if.source                          out_ch,
  input  logic                               cfg_we_i,
  input  logic [gtg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gtg_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // Core depth: the root needs SQRT_BITS stages, the CORDIC one per step.
  localparam int unsigned CORE_STAGES =
    (CORDIC_STEPS > gtg_pkg::SQRT_BITS) ? CORDIC_STEPS : gtg_pkg::SQRT_BITS;

  logic [gtg_pkg::GAIN_W-1:0] lin_gain_q, ang_gain_q;

  logic            front_vld, front_rdy;
  gtg_pkg::front_t front_pl;
  logic            core_vld, core_rdy;
  gtg_pkg::core_t  core_pl;

  // Gain registers: an unknown index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_gain_q <= gtg_pkg::LIN_GAIN_RST;
      ang_gain_q <= gtg_pkg::ANG_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gtg_pkg::CFG_LINEAR_GAIN:  lin_gain_q <= cfg_data_i;
        gtg_pkg::CFG_ANGULAR_GAIN: ang_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end: dx/dy, squares, half-plane fold, radicand.
  gtg_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_ch.valid),
    .in_ready_o      (in_ch.ready),
    .robot_x_i       (in_ch.robot_x),
    .robot_y_i       (in_ch.robot_y),
    .robot_heading_i (in_ch.robot_heading),
    .goal_x_i        (in_ch.goal_x),
    .goal_y_i        (in_ch.goal_y),
    .out_valid_o     (front_vld),
    .out_ready_i     (front_rdy),
    .out_o           (front_pl)
  );

  // Core: exact integer root and atan2 side by side, one step per stage.
  gtg_core #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .STAGES       (CORE_STAGES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_vld),
    .in_ready_o  (front_rdy),
    .in_i        (front_pl),
    .out_valid_o (core_vld),
    .out_ready_i (core_rdy),
    .out_o       (core_pl)
  );

  // Back end: heading error, gains, rounding, saturation, output register.
  gtg_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .linear_gain_i   (lin_gain_q),
    .angular_gain_i  (ang_gain_q),
    .in_valid_i      (core_vld),
    .in_ready_o      (core_rdy),
    .in_i            (core_pl),
    .out_valid_o     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .linear_speed_o  (out_ch.linear_speed),
    .angular_speed_o (out_ch.angular_speed)
  );

endmodule

// ----- sv/gtg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_checker: port-level checks of the go-to-goal velocity block
// Tracks beats in flight and checks output hold and pipeline liveness.
// ----------------------------------------------------------------------------
module gtg_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [gtg_pkg::LIN_W-1:0]         linear_speed_i,
  input  logic signed [gtg_pkg::ANG_W-1:0]  angular_speed_i
);

  logic [7:0] cnt_q, cnt_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) cnt_d = cnt_q + 8'd1;
    if (!in_acc && out_acc) cnt_d = cnt_q - 8'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(linear_speed_i) && $stable(angular_speed_i))
    else $error("result changed while stalled");

  // every result belongs to an accepted beat
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != 8'd0)
    else $error("result without a pending beat");

  // an empty pipeline always takes a beat
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 8'd0 |-> in_ready_i)
    else $error("input blocked while nothing is in flight");

endmodule

bind go_to_goal_velocity gtg_checker u_gtg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_ch.valid),
  .in_ready_i      (in_ch.ready),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .linear_speed_i  (out_ch.linear_speed),
  .angular_speed_i (out_ch.angular_speed)
);
